FILE: hw/rtl/b32e_pkg.sv
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types and constants for the base32 stream encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

  localparam int SymW     = 5;
  localparam int CharW    = 7;
  localparam int NumSyms  = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 56;
  localparam int MaxSyms  = 3;

  localparam logic [CharW-1:0] PadCharReset = 7'd61;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALPHA0   = 3'd0,
    CFG_ALPHA1   = 3'd1,
    CFG_ALPHA2   = 3'd2,
    CFG_ALPHA3   = 3'd3,
    CFG_PAD_EN   = 3'd4,
    CFG_PAD_CHAR = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             final_char;
    logic             message_done;
  } out_t;

  typedef logic [NumSyms-1:0][CharW-1:0] alphabet_t;

  // One classified request: the symbols to look up, in order, then pads.
  typedef struct packed {
    logic [MaxSyms-1:0][SymW-1:0] sym;
    logic [1:0]                   nsym;
    logic [2:0]                   npad;
    logic                         last;
  } op_t;

endpackage

FILE: hw/rtl/b32e_front.sv
// ----------------------------------------------------------------------------
// b32e_front
// Accepts bytes, tracks leftover bits and quantum position, and turns each
// request into a list of symbols and a pad count.
// ----------------------------------------------------------------------------
module b32e_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  b32e_pkg::in_t   in_data,
  input  logic            pad_en,
  input  logic            q_full,
  output logic            push,
  output b32e_pkg::op_t   push_op
);
  import b32e_pkg::*;

  logic [3:0]  lb_r, lb_nxt;
  logic [2:0]  lc_r, lc_nxt;
  logic [2:0]  qpos_r, qpos_nxt;
  logic [2:0]  cnt;
  logic [11:0] acc;
  logic [3:0]  bits;
  logic        two;
  logic [2:0]  rem;
  logic [3:0]  new_lb;
  logic        extra;
  logic [4:0]  sym0, sym1, symx;
  logic [1:0]  nsym;
  logic [2:0]  qpos_after;
  logic [2:0]  pads;
  logic [3:0]  room;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    cnt    = (lc_r > 3'd4) ? 3'd4 : lc_r;
    acc    = {lb_r, in_data.data_byte};
    bits   = {1'b0, cnt} + 4'd8;
    two    = (bits >= 4'd10);
    sym0   = 5'(acc >> (bits - 4'd5));
    sym1   = 5'(acc >> (bits - 4'd10));
    rem    = two ? 3'(bits - 4'd10) : 3'(bits - 4'd5);
    new_lb = acc[3:0] & 4'((5'd1 << rem) - 5'd1);
    extra  = in_data.end_of_message && (rem != 3'd0);
    symx   = 5'({1'b0, new_lb} << (3'd5 - rem));
    nsym   = 2'd1 + {1'b0, two} + {1'b0, extra};
    qpos_after = qpos_r + {1'b0, nsym};
    pads   = (in_data.end_of_message && pad_en) ? 3'(3'd0 - qpos_after) : 3'd0;
    room   = 4'd8 - {2'b00, nsym};
    if ({1'b0, pads} > room) begin
      pads = room[2:0];
    end

    push_op.sym[0] = sym0;
    push_op.sym[1] = two ? sym1 : symx;
    push_op.sym[2] = symx;
    push_op.nsym   = nsym;
    push_op.npad   = pads;
    push_op.last   = in_data.end_of_message;

    lb_nxt   = lb_r;
    lc_nxt   = lc_r;
    qpos_nxt = qpos_r;
    if (push) begin
      if (in_data.end_of_message) begin
        lb_nxt   = 4'd0;
        lc_nxt   = 3'd0;
        qpos_nxt = 3'd0;
      end else begin
        lb_nxt   = new_lb;
        lc_nxt   = rem;
        qpos_nxt = qpos_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb_r   <= 4'd0;
      lc_r   <= 3'd0;
      qpos_r <= 3'd0;
    end else begin
      lb_r   <= lb_nxt;
      lc_r   <= lc_nxt;
      qpos_r <= qpos_nxt;
    end
  end

endmodule

FILE: hw/rtl/b32e_queue.sv
// ----------------------------------------------------------------------------
// b32e_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module b32e_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b32e_pkg::op_t   push_op,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output b32e_pkg::op_t   head_op,
  output logic [1:0]      count
);
  import b32e_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_op    = mem_r[rd_ptr_r];
  assign count      = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/b32e_back.sv
// ----------------------------------------------------------------------------
// b32e_back
// Walks the queue head request, one character per cycle unless stalled,
// through the alphabet lookup and pad character, into the output register.
// ----------------------------------------------------------------------------
module b32e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  b32e_pkg::op_t       head_op,
  output logic                pop,
  input  b32e_pkg::alphabet_t alphabet,
  input  logic [6:0]          pad_char,
  output logic                out_valid,
  input  logic                out_ready,
  output b32e_pkg::out_t      out_data
);
  import b32e_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic [2:0] pcnt_r, pcnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r;
  logic       advance;
  logic       in_syms;
  logic       fin;
  logic [4:0] sym_sel;
  logic [6:0] ch;

  assign advance   = head_valid && (!out_valid_r || out_ready);
  assign pop       = advance && fin;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    in_syms = (idx_r < head_op.nsym);
    case (idx_r)
      2'd0:    sym_sel = head_op.sym[0];
      2'd1:    sym_sel = head_op.sym[1];
      2'd2:    sym_sel = head_op.sym[2];
      default: sym_sel = head_op.sym[0];
    endcase
    ch = in_syms ? alphabet[sym_sel] : pad_char;
    if (in_syms) begin
      fin = (idx_r == head_op.nsym - 2'd1) && (head_op.npad == 3'd0);
    end else begin
      fin = (pcnt_r == head_op.npad - 3'd1);
    end

    idx_nxt  = idx_r;
    pcnt_nxt = pcnt_r;
    if (advance) begin
      if (fin) begin
        idx_nxt  = 2'd0;
        pcnt_nxt = 3'd0;
      end else if (in_syms) begin
        idx_nxt = idx_r + 2'd1;
      end else begin
        pcnt_nxt = pcnt_r + 3'd1;
      end
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.out_char     <= ch;
      out_data_r.final_char   <= fin;
      out_data_r.message_done <= fin && head_op.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      pcnt_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/base32_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// base32_stream_encoder_top
// Base32 encoder with a configurable alphabet and optional padding.
// ----------------------------------------------------------------------------
// Each byte request produces one or two characters, and the final byte of a
// message produces up to eight, counting the zero-filled tail and the pad
// characters. The output side delivers one character per cycle while
// out_ready is high; the front takes a new byte in any cycle that the
// two-entry request queue has room, and the single output register sets the
// sustained rate. Configuration writes are accepted in every cycle and must
// be made while no message is in flight.
module base32_stream_encoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  b32e_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output b32e_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [b32e_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [b32e_pkg::CfgDataW-1:0]  cfg_data
);
  import b32e_pkg::*;

  alphabet_t        alpha_r;
  logic             pad_en_r;
  logic [CharW-1:0] pad_char_r;
  logic             q_full;
  logic             q_head_valid;
  op_t              q_head_op;
  op_t              push_op;
  logic             q_push;
  logic             q_pop;
  logic [1:0]       q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r    <= '0;
      pad_en_r   <= 1'b0;
      pad_char_r <= PadCharReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALPHA0:   alpha_r[7:0]   <= cfg_data;
        CFG_ALPHA1:   alpha_r[15:8]  <= cfg_data;
        CFG_ALPHA2:   alpha_r[23:16] <= cfg_data;
        CFG_ALPHA3:   alpha_r[31:24] <= cfg_data;
        CFG_PAD_EN:   pad_en_r       <= cfg_data[0];
        CFG_PAD_CHAR: pad_char_r     <= cfg_data[CharW-1:0];
        default:      ;
      endcase
    end
  end

  b32e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .pad_en   (pad_en_r),
    .q_full   (q_full),
    .push     (q_push),
    .push_op  (push_op)
  );

  b32e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (push_op),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_op    (q_head_op),
    .count      (q_count)
  );

  b32e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_op    (q_head_op),
    .pop        (q_pop),
    .alphabet   (alpha_r),
    .pad_char   (pad_char_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // The back never removes a request from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_count != 2'd0))
    else $error("request popped from empty queue");

  // The queue never holds more than two requests.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count != 2'd3))
    else $error("queue count out of range");

  // The end of a message is always the last character of its byte.
  a_done_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.message_done) |-> out_data.final_char)
    else $error("message end without final character");

endmodule

FILE: bench/b32e_char_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_char_checker
// Watches the byte, character and register channels of the base32 encoder,
// works out the characters that each accepted byte request must produce,
// and compares every accepted character with the oldest one still owed.
// ----------------------------------------------------------------------------
module b32e_char_checker
  import b32e_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_t                 in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_t                out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  error_count,
  output int                  pending_count,
  output int                  chars_checked
);

  localparam int MaxChars = 8;

  logic [3:0][CfgDataW-1:0] alpha_words;
  logic                     pad_on;
  logic [CharW-1:0]         pad_code;

  logic [3:0] rem_bits;
  logic [2:0] rem_count;
  logic [2:0] quant_pos;

  out_t owed_chars[$];
  out_t char_batch[MaxChars];
  int   batch_len;
  int   errs;
  int   checked;

  function automatic logic [CharW-1:0] symbol_char(input logic [SymW-1:0] sym);
    return alpha_words[sym[4:3]][sym[2:0]*CharW +: CharW];
  endfunction

  function automatic void add_char(input logic [CharW-1:0] code);
    out_t c;
    if (batch_len < MaxChars) begin
      c.out_char     = code;
      c.final_char   = 1'b0;
      c.message_done = 1'b0;
      char_batch[batch_len] = c;
      batch_len++;
      quant_pos = quant_pos + 3'd1;
    end
  endfunction

  function automatic void encode_byte(input in_t item);
    logic [11:0]     acc;
    logic [11:0]     shifted;
    logic [SymW-1:0] tail;
    out_t            c;
    int              bits;
    batch_len = 0;
    acc  = {rem_bits, item.data_byte};
    bits = int'(rem_count) + 8;
    while (bits >= SymW) begin
      bits    = bits - SymW;
      shifted = acc >> bits;
      add_char(symbol_char(shifted[SymW-1:0]));
    end
    rem_count = bits[2:0];
    rem_bits  = acc[3:0] & ((4'd1 << bits) - 4'd1);
    if (item.end_of_message) begin
      if (rem_count != 3'd0) begin
        tail = {1'b0, rem_bits} << (SymW - int'(rem_count));
        add_char(symbol_char(tail));
      end
      if (pad_on) begin
        while (quant_pos != 3'd0 && batch_len < MaxChars) begin
          add_char(pad_code);
        end
      end
      rem_bits  = '0;
      rem_count = '0;
      quant_pos = '0;
    end
    c = char_batch[batch_len-1];
    c.final_char   = 1'b1;
    c.message_done = item.end_of_message;
    char_batch[batch_len-1] = c;
    for (int i = 0; i < batch_len; i++) begin
      owed_chars.push_back(char_batch[i]);
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      alpha_words = '0;
      pad_on      = 1'b0;
      pad_code    = PadCharReset;
      rem_bits    = '0;
      rem_count   = '0;
      quant_pos   = '0;
      owed_chars.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_chars.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("%t: unexpected character: char %h final %b done %b", $realtime,
                     out_data.out_char, out_data.final_char, out_data.message_done);
          end
        end else begin
          want = owed_chars.pop_front();
          checked++;
          if (out_data.out_char !== want.out_char ||
              out_data.final_char !== want.final_char ||
              out_data.message_done !== want.message_done) begin
            errs++;
            if (errs <= 10) begin
              $display("%t: character %0d mismatch: expected char %h final %b done %b, got char %h final %b done %b",
                       $realtime, checked, want.out_char, want.final_char, want.message_done,
                       out_data.out_char, out_data.final_char, out_data.message_done);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALPHA0:   alpha_words[0] = cfg_data;
          CFG_ALPHA1:   alpha_words[1] = cfg_data;
          CFG_ALPHA2:   alpha_words[2] = cfg_data;
          CFG_ALPHA3:   alpha_words[3] = cfg_data;
          CFG_PAD_EN:   pad_on         = cfg_data[0];
          CFG_PAD_CHAR: pad_code       = cfg_data[CharW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        encode_byte(in_data);
      end
    end
    error_count   <= errs;
    pending_count <= owed_chars.size();
    chars_checked <= checked;
  end

endmodule

FILE: bench/tb_base32_stream_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base32_stream_encoder_top
// Drives byte requests and register writes into the base32 encoder under
// random gaps and output stalls. Short directed messages cover the reset
// alphabet, extreme bytes and every quantum remainder, then random messages
// run under several alphabet and padding settings, while the checker
// predicts and compares every character.
// ----------------------------------------------------------------------------
module tb_base32_stream_encoder_top;
  import b32e_pkg::*;

  localparam int PhaseItems    = 56;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 20;

  localparam logic [CfgIdxW-1:0]  CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0]  CfgSpareHi = 3'd7;
  localparam logic [CfgDataW-1:0] WordOnes   = '1;
  localparam logic [CfgDataW-1:0] WordZeros  = '0;
  localparam logic [CharW-1:0]    CharMin    = '0;
  localparam logic [CharW-1:0]    CharMax    = '1;

  typedef logic [3:0][CfgDataW-1:0] alpha_words_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int error_count;
  int pending_count;
  int chars_checked;
  int idle_cycles;
  int bytes_sent;
  int messages_sent;
  bit tx_burst;

  base32_stream_encoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  b32e_char_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count),
    .chars_checked (chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%t: watchdog expired with %0d characters outstanding", $realtime,
                 pending_count);
        $display("tb_base32_stream_encoder_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int  stall;
    bit  rx_burst;
    rx_burst = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        rx_burst = !rx_burst;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic alpha_words_t pack_alphabet(input string chars);
    alpha_words_t words;
    byte          c;
    words = '0;
    for (int i = 0; i < NumSyms; i++) begin
      c = chars[i];
      words[i/8][(i%8)*CharW +: CharW] = c[CharW-1:0];
    end
    return words;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input alpha_words_t words, input logic pad_en,
                               input logic [CharW-1:0] pad_ch, input bit with_spare);
    logic [63:0] rnd;
    write_reg(CFG_ALPHA0, words[0]);
    write_reg(CFG_ALPHA1, words[1]);
    write_reg(CFG_ALPHA2, words[2]);
    write_reg(CFG_ALPHA3, words[3]);
    if (with_spare) begin
      rnd = {$urandom, $urandom};
      write_reg(CfgSpareLo, rnd[CfgDataW-1:0]);
      write_reg(CfgSpareHi, WordOnes);
    end
    write_reg(CFG_PAD_EN, CfgDataW'(pad_en));
    write_reg(CFG_PAD_CHAR, CfgDataW'(pad_ch));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last);
    in_t item;
    int  gap;
    item.data_byte      = data;
    item.end_of_message = last;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (last) begin
      messages_sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic random_phase(input alpha_words_t words, input logic pad_en,
                              input logic [CharW-1:0] pad_ch);
    int          count;
    int          len;
    logic [31:0] rnd;
    load_settings(words, pad_en, pad_ch, 1'b0);
    count = 0;
    while (count < PhaseItems) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8);
      tx_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        rnd = $urandom;
        send_byte(rnd[7:0], k == len - 1);
      end
      count += len;
    end
    drain();
  endtask

  initial begin
    logic [7:0]   pattern [4];
    alpha_words_t std_words;
    alpha_words_t rnd_words;
    logic [63:0]  rnd;
    pattern[0] = 8'hFF;
    pattern[1] = 8'h00;
    pattern[2] = 8'hAA;
    pattern[3] = 8'h55;
    tx_burst   = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // With the reset alphabet every symbol encodes to zero and padding is off.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    std_words = pack_alphabet("ABCDEFGHIJKLMNOPQRSTUVWXYZ234567");
    load_settings(std_words, 1'b1, PadCharReset, 1'b1);
    for (int len = 1; len <= 5; len++) begin
      for (int k = 0; k < len; k++) begin
        send_byte(pattern[(len + k) % 4], k == len - 1);
      end
    end
    drain();

    random_phase(pack_alphabet("abcdefghijklmnopqrstuvwxyz234567"), 1'b1, PadCharReset);
    random_phase(pack_alphabet("0123456789ABCDEFGHJKMNPQRSTVWXYZ"), 1'b0, PadCharReset);
    random_phase({WordOnes, WordOnes, WordOnes, WordOnes}, 1'b1, CharMin);
    for (int w = 0; w < 4; w++) begin
      rnd = {$urandom, $urandom};
      rnd_words[w] = rnd[CfgDataW-1:0];
    end
    // The pad character doubles as the code of symbol zero here.
    random_phase(rnd_words, 1'b1, rnd_words[0][CharW-1:0]);
    random_phase({WordZeros, WordZeros, WordZeros, WordZeros}, 1'b1, CharMax);

    drain();
    repeat (DrainCycles) @(posedge clk);
    $display("Run covered %0d bytes in %0d messages, %0d characters checked,",
             bytes_sent, messages_sent, chars_checked);
    $display("over seven alphabet and padding settings with random gaps and stalls.");
    if (error_count == 0 && pending_count == 0) begin
      $display("tb_base32_stream_encoder_top: done, clean");
    end else begin
      $display("tb_base32_stream_encoder_top: done, errors");
    end
    $finish;
  end

endmodule
